>>> design/cdbs_pkg.sv
// ----------------------------------------------------------------------------
// cdbs_pkg
// Shared types and constants of the character display buffer with scrolling.
// ----------------------------------------------------------------------------
package cdbs_pkg;

   // command codes
   localparam logic [3:0] ACT_CLEAR_ALL = 4'd0;
   localparam logic [3:0] ACT_CLEAR_ROW = 4'd1;
   localparam logic [3:0] ACT_SET_CHAR  = 4'd2;
   localparam logic [3:0] ACT_SCROLL_L  = 4'd3;
   localparam logic [3:0] ACT_SCROLL_R  = 4'd4;
   localparam logic [3:0] ACT_ROT_L     = 4'd5;
   localparam logic [3:0] ACT_ROT_R     = 4'd6;
   localparam logic [3:0] ACT_ROT_UP    = 4'd7;
   localparam logic [3:0] ACT_ROT_DN    = 4'd8;
   localparam logic [3:0] ACT_READ_CHAR = 4'd9;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   localparam int ROWS_REG_W = 3;
   localparam int COLS_REG_W = 6;
   localparam int RST_ROWS   = 2;
   localparam int RST_COLS   = 20;

   localparam logic [7:0] SPACE_CODE = 8'h20;

   typedef struct packed {
      logic [3:0] action;
      logic [1:0] row;
      logic [4:0] col;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       accepted;
   } rsp_type;

endpackage

>>> design/char_display_buffer_scroll_core.sv
// ----------------------------------------------------------------------------
// char_display_buffer_scroll_core
// Character display store of MAX_ROWS x MAX_COLS bytes with row commands.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one command per
//   beat; rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//   result beat per command. csr channel (csr_valid / csr_ready) writes the
//   rows and columns in use; csr_ready is always high. Write it only while
//   the block is idle.
//   One command is worked at a time; req_stall stays high until its result
//   is loaded into the output register. Set char, rotate up/down and a
//   rejected command go straight to the last step; read char first reads
//   its cell; clear row writes spaces over the row's columns in use;
//   scroll / rotate a row reads each cell and writes it one place over,
//   then fills the freed end with the wrapped cell or a space; clear all
//   runs the clearing pass. Row passes work one cell a cycle.
//   Reset and every size register write start a clearing pass that writes
//   spaces to every cell; req_stall is high during it. A result held by
//   rsp_stall does not block acceptance of the next command; that command
//   waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module char_display_buffer_scroll_core #(
   parameter int MAX_ROWS = 4,
   parameter int MAX_COLS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cdbs_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cdbs_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cdbs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cdbs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int TOTAL = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(TOTAL);
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int ROWS_RST = (cdbs_pkg::RST_ROWS > MAX_ROWS) ? MAX_ROWS : cdbs_pkg::RST_ROWS;
   localparam int COLS_RST = (cdbs_pkg::RST_COLS > MAX_COLS) ? MAX_COLS : cdbs_pkg::RST_COLS;
   localparam logic [AW-1:0] COLS_A   = AW'(MAX_COLS);
   localparam logic [AW-1:0] LAST_A   = AW'(TOTAL - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WIPE  = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_SHEND = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      ptr_ff, ptr_in;          // clearing pass address
   logic               wipe_rsp_ff, wipe_rsp_in; // clearing pass owes a result
   logic [CNW-1:0]     cnt_ff, cnt_in;          // column counter of a row pass
   logic [AW-1:0]      base_ff, base_in;        // first cell of the addressed row
   logic               left_ff, left_in;
   logic               rot_ff, rot_in;
   logic [7:0]         keep_ff, keep_in;        // cell that wraps around, or a space for a scroll
   logic               dv_ff, dv_in;            // read data in flight
   logic               dfirst_ff, dfirst_in;
   logic [CW-1:0]      dcol_ff, dcol_in;
   logic [7:0]         res_char_ff, res_char_in;
   logic               res_ok_ff, res_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cdbs_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic [RNW-1:0]     rows_ff, rows_in;
   logic [CNW-1:0]     cols_ff, cols_in;
   logic [RW-1:0]      ord_ff [MAX_ROWS];
   logic [RW-1:0]      ord_in [MAX_ROWS];
   logic [RW-1:0]      ord_up [MAX_ROWS];
   logic [RW-1:0]      ord_dn [MAX_ROWS];

   // cell memory: one write and one registered read a cycle
   logic [7:0]         mem [TOTAL];
   logic [7:0]         rdata_ff;
   logic               we;
   logic [AW-1:0]      waddr;
   logic [7:0]         wdata;
   logic [AW-1:0]      raddr;

   logic               accept;
   logic               out_free;
   logic               row_ok;
   logic               col_ok;
   logic [RW-1:0]      ord_idx;
   logic [RW-1:0]      phys;
   logic [AW-1:0]      acc_base;
   logic [AW-1:0]      acc_addr;
   logic               issue;
   logic [CW-1:0]      shift_col;
   logic [CW-1:0]      dest_col;
   logic [CW-1:0]      last_col;
   logic               csr_wr;
   int                 lim_rows;
   int                 lim_cols;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_wr   = csr_valid && csr_ready &&
                     ((csr_index == cdbs_pkg::CSR_ROWS) || (csr_index == cdbs_pkg::CSR_COLS));

   // range checks against the sizes in use
   assign row_ok = int'(req_data.row) < int'(rows_ff);
   assign col_ok = int'(req_data.col) < int'(cols_ff);

   // one row order lookup serves both the addressed row and the tail for rotate down
   assign ord_idx  = (req_data.action == cdbs_pkg::ACT_ROT_DN) ?
                     RW'(rows_ff - RNW'(1)) : RW'(req_data.row);
   assign phys     = ord_ff[ord_idx];
   assign acc_base = AW'(phys) * COLS_A;
   assign acc_addr = acc_base + AW'(CW'(req_data.col));

   // row pass column arithmetic
   assign issue     = int'(cnt_ff) < int'(cols_ff);
   assign shift_col = left_ff ? CW'(cnt_ff) : CW'(cols_ff - CNW'(1) - cnt_ff);
   assign dest_col  = left_ff ? (dcol_ff - CW'(1)) : (dcol_ff + CW'(1));
   assign last_col  = CW'(cols_ff - CNW'(1));

   // rotate the rows in use cyclically
   always_comb begin
      for (int i = 0; i < MAX_ROWS; i++) begin
         if (i + 1 < int'(rows_ff)) begin
            ord_up[i] = ord_ff[RW'((i + 1) % MAX_ROWS)];
         end else if (i + 1 == int'(rows_ff)) begin
            ord_up[i] = ord_ff[0];
         end else begin
            ord_up[i] = ord_ff[i];
         end
         if (i == 0) begin
            ord_dn[i] = phys;
         end else if (i < int'(rows_ff)) begin
            ord_dn[i] = ord_ff[RW'((i + MAX_ROWS - 1) % MAX_ROWS)];
         end else begin
            ord_dn[i] = ord_ff[i];
         end
      end
   end

   // clamp a size register write
   always_comb begin
      lim_rows = int'(csr_wdata[cdbs_pkg::ROWS_REG_W-1:0]);
      if (lim_rows < 1) begin
         lim_rows = 1;
      end else if (lim_rows > MAX_ROWS) begin
         lim_rows = MAX_ROWS;
      end
      lim_cols = int'(csr_wdata[cdbs_pkg::COLS_REG_W-1:0]);
      if (lim_cols < 1) begin
         lim_cols = 1;
      end else if (lim_cols > MAX_COLS) begin
         lim_cols = MAX_COLS;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      wipe_rsp_in  = wipe_rsp_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      left_in      = left_ff;
      rot_in       = rot_ff;
      keep_in      = keep_ff;
      dv_in        = 1'b0;
      dfirst_in    = dfirst_ff;
      dcol_in      = dcol_ff;
      res_char_in  = res_char_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      ord_in       = ord_ff;
      we           = 1'b0;
      waddr        = ptr_ff;
      wdata        = cdbs_pkg::SPACE_CODE;
      raddr        = acc_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_char_in = 8'd0;
               res_ok_in   = 1'b0;
               state_in    = ST_DONE;
               base_in     = acc_base;
               cnt_in      = '0;
               unique case (req_data.action) inside
                  cdbs_pkg::ACT_CLEAR_ALL: begin
                     res_ok_in   = 1'b1;
                     ptr_in      = '0;
                     wipe_rsp_in = 1'b1;
                     state_in    = ST_WIPE;
                  end
                  cdbs_pkg::ACT_CLEAR_ROW: begin
                     if (row_ok) begin
                        state_in = ST_FILL;
                     end
                  end
                  cdbs_pkg::ACT_SET_CHAR: begin
                     if (row_ok && col_ok) begin
                        we        = 1'b1;
                        waddr     = acc_addr;
                        wdata     = req_data.char_in;
                        res_ok_in = 1'b1;
                     end
                  end
                  cdbs_pkg::ACT_SCROLL_L, cdbs_pkg::ACT_SCROLL_R,
                  cdbs_pkg::ACT_ROT_L, cdbs_pkg::ACT_ROT_R: begin
                     if (row_ok) begin
                        left_in  = (req_data.action == cdbs_pkg::ACT_SCROLL_L) ||
                                   (req_data.action == cdbs_pkg::ACT_ROT_L);
                        rot_in   = (req_data.action == cdbs_pkg::ACT_ROT_L) ||
                                   (req_data.action == cdbs_pkg::ACT_ROT_R);
                        state_in = ST_SHIFT;
                     end
                  end
                  cdbs_pkg::ACT_ROT_UP: begin
                     ord_in    = ord_up;
                     res_ok_in = 1'b1;
                  end
                  cdbs_pkg::ACT_ROT_DN: begin
                     ord_in    = ord_dn;
                     res_ok_in = 1'b1;
                  end
                  cdbs_pkg::ACT_READ_CHAR: begin
                     // read issued at this edge, data lands next cycle
                     if (row_ok && col_ok) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WIPE: begin
            we     = 1'b1;
            waddr  = ptr_ff;
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == LAST_A) begin
               state_in = wipe_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_FILL: begin
            we     = 1'b1;
            waddr  = base_ff + AW'(CW'(cnt_ff));
            cnt_in = cnt_ff + CNW'(1);
            if (int'(cnt_ff) + 1 == int'(cols_ff)) begin
               res_ok_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_SHIFT: begin
            // issue one read a cycle, write each returned cell but the first one place over
            raddr = base_ff + AW'(shift_col);
            if (issue) begin
               cnt_in    = cnt_ff + CNW'(1);
               dv_in     = 1'b1;
               dcol_in   = shift_col;
               dfirst_in = (cnt_ff == '0);
            end
            if (dv_ff) begin
               if (dfirst_ff) begin
                  keep_in = rot_ff ? rdata_ff : cdbs_pkg::SPACE_CODE;
               end else begin
                  we    = 1'b1;
                  waddr = base_ff + AW'(dest_col);
                  wdata = rdata_ff;
               end
               if (!issue) begin
                  state_in = ST_SHEND;
               end
            end
         end
         ST_SHEND: begin
            // drop the wrapped cell, or a space for a scroll, into the freed end
            we        = 1'b1;
            waddr     = base_ff + (left_ff ? AW'(last_col) : AW'(0));
            wdata     = keep_ff;
            res_ok_in = 1'b1;
            state_in  = ST_DONE;
         end
         ST_READ: begin
            res_char_in = rdata_ff;
            res_ok_in   = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.char_out = res_char_ff;
               rsp_data_in.accepted = res_ok_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // size write: restart the clearing pass and the row order
      if (csr_wr) begin
         if (csr_index == cdbs_pkg::CSR_ROWS) begin
            rows_in = RNW'(lim_rows);
         end else begin
            cols_in = CNW'(lim_cols);
         end
         for (int i = 0; i < MAX_ROWS; i++) begin
            ord_in[i] = RW'(i);
         end
         ptr_in      = '0;
         wipe_rsp_in = 1'b0;
         state_in    = ST_WIPE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         ptr_ff       <= '0;
         wipe_rsp_ff  <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= RNW'(ROWS_RST);
         cols_ff      <= CNW'(COLS_RST);
         for (int i = 0; i < MAX_ROWS; i++) begin
            ord_ff[i] <= RW'(i);
         end
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         wipe_rsp_ff  <= wipe_rsp_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         ord_ff       <= ord_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      base_ff     <= base_in;
      left_ff     <= left_in;
      rot_ff      <= rot_in;
      keep_ff     <= keep_in;
      dfirst_ff   <= dfirst_in;
      dcol_ff     <= dcol_in;
      res_char_ff <= res_char_in;
      res_ok_ff   <= res_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // cell memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

>>> design/cdbs_checker.sv
// ----------------------------------------------------------------------------
// cdbs_checker
// Port level checks of the character display buffer, bound to the top level.
// ----------------------------------------------------------------------------
module cdbs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input cdbs_pkg::rsp_type                 rsp_data,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [cdbs_pkg::CSR_IDX_W-1:0]    csr_index
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // a rejected command never carries a character
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> rsp_data.char_out == 8'd0)
      else $error("rejected command returned a character");

   // one command at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken while one is in work");

   // reset starts the clearing pass
   a_reset_wipe: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("command channel open right after reset");

   // a size register write clears the store before new commands
   a_csr_wipe: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready &&
      (csr_index == cdbs_pkg::CSR_ROWS || csr_index == cdbs_pkg::CSR_COLS)
      |=> req_stall)
      else $error("command channel open right after a size write");

endmodule

bind char_display_buffer_scroll_core cdbs_checker u_cdbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index)
);
